// ===== sv/bpc_pkg.sv =====
// shared types, event codes and register indexes of the button press classifier
package bpc_pkg;

    localparam int TIME_W     = 32;
    localparam int DEB_W      = 16;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    // latched event codes
    typedef logic [1:0] event_t;
    localparam event_t EV_NONE  = 2'd0;
    localparam event_t EV_PRESS = 2'd1;
    localparam event_t EV_LONG  = 2'd2;
    localparam event_t EV_HOLD  = 2'd3;

    // configuration register indexes
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_LONG_PRESS = 2'd0;
    localparam cfg_idx_t REG_HOLD       = 2'd1;
    localparam cfg_idx_t REG_DEBOUNCE   = 2'd2;

    // register reset values
    localparam logic [TIME_W-1:0] LONG_PRESS_RST = 32'd1000;
    localparam logic [TIME_W-1:0] HOLD_RST       = 32'd2000;
    localparam logic [DEB_W-1:0]  DEBOUNCE_RST   = 16'd50;

    typedef struct packed {
        logic [TIME_W-1:0] long_lim;
        logic [TIME_W-1:0] hold_ms;
        logic [DEB_W-1:0]  deb_lim;
    } cfg_t;

    // per-lane view of one request
    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              level;
        logic              upd;
        logic              inj_hit;
        event_t            inj_event;
    } lane_req_t;

endpackage

// ===== sv/bpc_lane.sv =====
// per-button press tracker: edge detect, held time and event latch
module bpc_lane
    import bpc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  lane_req_t req,
    input  logic      rd_clear,
    output event_t    latched_upd
);

    logic              prev_reg, prev_next;
    logic              active_reg, active_next;
    logic [TIME_W-1:0] start_reg, start_next;
    logic              lf_reg, lf_next;
    logic              hf_reg, hf_next;
    event_t            latched_reg, latched_next;

    logic              rise;
    logic              fall;
    logic              act_eff;
    logic              lf_eff;
    logic              hf_eff;
    logic [TIME_W-1:0] start_eff;
    logic [TIME_W-1:0] held;
    logic              hold_hit;
    logic              long_hit;
    logic              deb_hit;

    // held time and threshold compares
    always_comb
    begin
        rise      = req.level & ~prev_reg;
        fall      = ~req.level & prev_reg;
        start_eff = rise ? req.now_ms : start_reg;
        act_eff   = rise | active_reg;
        lf_eff    = rise ? 1'b0 : lf_reg;
        hf_eff    = rise ? 1'b0 : hf_reg;
        held      = req.now_ms - start_eff;
        hold_hit  = held >= cfg.hold_ms;
        long_hit  = held >= cfg.long_lim;
        deb_hit   = held >= {{(TIME_W-DEB_W){1'b0}}, cfg.deb_lim};
    end

    // state update for this tick
    always_comb
    begin
        prev_next   = req.level;
        active_next = act_eff;
        start_next  = start_eff;
        lf_next     = lf_eff;
        hf_next     = hf_eff;
        latched_upd = latched_reg;

        if (req.level && act_eff)
        begin
            if (hold_hit && !hf_eff)
            begin
                latched_upd = EV_HOLD;
                hf_next     = 1'b1;
            end
            else if (long_hit && !lf_eff && !hf_eff)
            begin
                latched_upd = EV_LONG;
                lf_next     = 1'b1;
            end
        end

        // release ends the press
        if (fall)
        begin
            if (!lf_reg && !hf_reg && deb_hit)
            begin
                latched_upd = EV_PRESS;
            end
            active_next = 1'b0;
            start_next  = '0;
            lf_next     = 1'b0;
            hf_next     = 1'b0;
        end

        // injected event replaces normal processing
        if (req.inj_hit)
        begin
            prev_next   = prev_reg;
            active_next = active_reg;
            start_next  = start_reg;
            lf_next     = lf_reg;
            hf_next     = hf_reg;
            latched_upd = req.inj_event;
        end

        latched_next = rd_clear ? EV_NONE : latched_upd;
    end

    // lane state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg    <= 1'b0;
            active_reg  <= 1'b0;
            start_reg   <= '0;
            lf_reg      <= 1'b0;
            hf_reg      <= 1'b0;
            latched_reg <= EV_NONE;
        end
        else if (req.upd)
        begin
            prev_reg    <= prev_next;
            active_reg  <= active_next;
            start_reg   <= start_next;
            lf_reg      <= lf_next;
            hf_reg      <= hf_next;
            latched_reg <= latched_next;
        end
    end

endmodule

// ===== sv/bpc_merge.sv =====
// merges lane results: selects the read event and drives the clear strobes
module bpc_merge
    import bpc_pkg::*;
#(
    parameter  int NUM_BUTTONS = 4,
    localparam int BTN_IDX_W   = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1
)
(
    input  event_t                 latched_upd [NUM_BUTTONS],
    input  logic                   rd_valid,
    input  logic [BTN_IDX_W-1:0]   rd_button,
    output logic [NUM_BUTTONS-1:0] rd_clear,
    output event_t                 read_event
);

    logic in_range;

    // index check and event select
    always_comb
    begin
        in_range   = {1'b0, rd_button} < (BTN_IDX_W+1)'(NUM_BUTTONS);
        read_event = EV_NONE;
        rd_clear   = '0;
        for (int b = 0; b < NUM_BUTTONS; b++)
        begin
            if (rd_valid && in_range && (rd_button == BTN_IDX_W'(b)))
            begin
                read_event  = latched_upd[b];
                rd_clear[b] = 1'b1;
            end
        end
    end

endmodule

// ===== sv/bpc_out_buf.sv =====
// two-entry output buffer that keeps the input side running under stall
module bpc_out_buf #(
    parameter int W = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);

    logic         main_valid_reg, main_valid_next;
    logic [W-1:0] main_data_reg, main_data_next;
    logic         skid_valid_reg, skid_valid_next;
    logic [W-1:0] skid_data_reg, skid_data_next;

    assign in_ready  = ~skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    // buffer steering
    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_data_next  = main_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (in_valid && in_ready)
        begin
            if (main_valid_reg && !out_ready)
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = in_data;
            end
            else
            begin
                main_valid_next = 1'b1;
                main_data_next  = in_data;
            end
        end
        else if (out_ready)
        begin
            if (skid_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = 1'b0;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// ===== sv/button_press_classifier_core.sv =====
// top level of the button press classifier: lanes, merge, output buffer, registers
// Classifies presses of NUM_BUTTONS buttons into short press, long press and hold.
// One tick request is taken every clock cycle while s_tready is high; its result
// is registered in the output buffer. Each button has its own lane with one 32-bit
// subtraction and three compares, all lanes working on the same tick in parallel,
// and a two-entry output buffer keeps s_tready high for one stalled result, so the
// rate is one tick per cycle as long as the result side keeps up. The latched
// event of the read button is taken after that tick's update and cleared. There is
// no clearing pass after reset. Configuration writes take effect on the next cycle
// and are meant to happen while no tick is in flight.
module button_press_classifier_core
    import bpc_pkg::*;
#(
    parameter  int NUM_BUTTONS = 4,
    localparam int BTN_IDX_W   = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1,
    localparam int IN_W        = TIME_W + NUM_BUTTONS + 1 + BTN_IDX_W + 2 + 1 + BTN_IDX_W,
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W       = 2 + NUM_BUTTONS,
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // tick request
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // now_ms, button_levels, inject_valid, inject_button, inject_event,
    // read_valid, read_button
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // result
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // read_event, pressed_levels
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // configuration writes
    input  logic                   cfg_we,
    input  cfg_idx_t               cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int LEV_LO  = TIME_W;
    localparam int IV_POS  = LEV_LO + NUM_BUTTONS;
    localparam int IB_LO   = IV_POS + 1;
    localparam int IE_LO   = IB_LO + BTN_IDX_W;
    localparam int RV_POS  = IE_LO + 2;
    localparam int RB_LO   = RV_POS + 1;

    cfg_t                   cfg_reg;
    logic                   accept;
    logic [TIME_W-1:0]      now_ms;
    logic [NUM_BUTTONS-1:0] button_levels;
    logic                   inject_valid;
    logic [BTN_IDX_W-1:0]   inject_button;
    event_t                 inject_event;
    logic                   read_valid;
    logic [BTN_IDX_W-1:0]   read_button;
    event_t                 latched_upd [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] rd_clear;
    event_t                 read_event;
    logic [OUT_TDATA_W-1:0] res_data;

    // request unpacking
    assign now_ms        = s_tdata[TIME_W-1:0];
    assign button_levels = s_tdata[LEV_LO +: NUM_BUTTONS];
    assign inject_valid  = s_tdata[IV_POS];
    assign inject_button = s_tdata[IB_LO +: BTN_IDX_W];
    assign inject_event  = s_tdata[IE_LO +: 2];
    assign read_valid    = s_tdata[RV_POS];
    assign read_button   = s_tdata[RB_LO +: BTN_IDX_W];

    assign accept = s_tvalid & s_tready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_lim <= LONG_PRESS_RST;
            cfg_reg.hold_ms  <= HOLD_RST;
            cfg_reg.deb_lim  <= DEBOUNCE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LONG_PRESS: cfg_reg.long_lim <= cfg_data;
                REG_HOLD:       cfg_reg.hold_ms  <= cfg_data;
                REG_DEBOUNCE:   cfg_reg.deb_lim  <= cfg_data[DEB_W-1:0];
                default:        ;
            endcase
        end
    end

    // one lane per button
    for (genvar b = 0; b < NUM_BUTTONS; b++)
    begin : g_lane
        lane_req_t req;

        always_comb
        begin
            req.now_ms    = now_ms;
            req.level     = button_levels[b];
            req.upd       = accept;
            req.inj_hit   = inject_valid && (inject_button == BTN_IDX_W'(b))
                            && (inject_event != EV_NONE);
            req.inj_event = inject_event;
        end

        bpc_lane u_lane (
            .clk         (clk),
            .rst_n       (rst_n),
            .cfg         (cfg_reg),
            .req         (req),
            .rd_clear    (rd_clear[b]),
            .latched_upd (latched_upd[b])
        );
    end

    // read select across lanes
    bpc_merge #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_merge (
        .latched_upd (latched_upd),
        .rd_valid    (read_valid),
        .rd_button   (read_button),
        .rd_clear    (rd_clear),
        .read_event  (read_event)
    );

    // result packing
    always_comb
    begin
        res_data            = '0;
        res_data[OUT_W-1:0] = {button_levels, read_event};
    end

    bpc_out_buf #(
        .W (OUT_TDATA_W)
    ) u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (res_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    // checks
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid)
        else $error("accepted tick produced no result");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    a_single_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(rd_clear))
        else $error("more than one lane cleared by one read");

endmodule
